### src/luhn_pkg.sv
// ----------------------------------------------------------------------------
// Luhn card validator package
// Shared item types, class codes and constants for the Luhn card validator.
// ----------------------------------------------------------------------------
package luhn_pkg;

  localparam int unsigned DigitW     = 4;
  localparam int unsigned CountW     = 5;
  localparam int unsigned ClassW     = 3;
  localparam int unsigned MaxDigitsDef = 19;

  localparam logic [DigitW-1:0] DigitMax = 4'd9;
  localparam logic [CountW-1:0] CountSat = 5'd31;

  // Card lengths that the classifier recognizes
  localparam logic [CountW-1:0] LenShort  = 5'd13;
  localparam logic [CountW-1:0] LenMid    = 5'd15;
  localparam logic [CountW-1:0] LenLong   = 5'd16;

  typedef enum logic [ClassW-1:0] {
    CLASS_INVALID = 3'd0,
    CLASS_PFX4    = 3'd1,
    CLASS_PFX3X   = 3'd2,
    CLASS_PFX5X   = 3'd3,
    CLASS_OTHER   = 3'd4
  } card_class_t;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              last_digit;
  } in_item_t;

  typedef struct packed {
    logic              valid_res;
    logic [ClassW-1:0] card_class;
    logic [CountW-1:0] digit_total;
  } out_item_t;

endpackage

### src/luhn_card_validator_unit.sv
// ----------------------------------------------------------------------------
// Luhn card validator unit
// Streams card digits, checks the Luhn sum and classifies the card number.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one decimal digit per
//   item, most significant first; last_digit marks the rightmost digit.
//   Output channel (out_valid/out_ready/out_data) carries one result item per
//   card number: Luhn validity, card class and digit count.
// Throughput: one digit per cycle while in_ready is high. Each digit updates
//   two running Luhn sums (one per doubling phase), each with a single mod-10
//   add, plus a saturating count and both leading digits; nothing iterates.
// Result: the result of a number appears on out_valid in the cycle after its
//   last digit is accepted, straight out of the result register.
// Stall: the result register holds its item while out_ready is low; in_ready
//   stays high while the result register is empty or being drained, so digits
//   keep flowing whenever the receiver keeps up. A full, stalled result
//   register blocks further digits.
// Reset: rst_n (synchronous, active low) clears the sums, count, leading
//   digits and the result valid flag; the block is ready the next cycle.
// After each last digit the running state clears for the next number.
// ----------------------------------------------------------------------------
module luhn_card_validator_unit
  import luhn_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [CountW-1:0] MaxLen = CountW'(MAX_DIGITS);

  // Running state for the number in progress
  logic [DigitW-1:0] sum_even_r, sum_even_nxt;
  logic [DigitW-1:0] sum_odd_r,  sum_odd_nxt;
  logic [CountW-1:0] count_r,    count_nxt;
  logic [DigitW-1:0] lead_first_r,  lead_first_nxt;
  logic [DigitW-1:0] lead_second_r, lead_second_nxt;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r,  out_item_nxt;

  logic              in_fire;
  logic [DigitW-1:0] d_sat;
  logic [DigitW:0]   d_two;
  logic [DigitW-1:0] d_dbl;
  logic [DigitW-1:0] add_even, add_odd;
  logic [DigitW:0]   raw_even, raw_odd;
  logic [DigitW-1:0] sum_sel;
  logic              luhn_ok;
  card_class_t       cls;

  // Take a digit while the result slot is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    // Clamp out-of-range codes to nine, then form the Luhn doubled digit
    d_sat = (in_data.digit > DigitMax) ? DigitMax : in_data.digit;
    d_two = {d_sat, 1'b0};
    d_dbl = (d_two > {1'b0, DigitMax}) ? DigitW'(d_two - 5'd9) : d_two[DigitW-1:0];

    // Even position (from the first digit) doubles in the even-phase sum
    if (!count_r[0]) begin
      add_even = d_dbl;
      add_odd  = d_sat;
    end else begin
      add_even = d_sat;
      add_odd  = d_dbl;
    end
    raw_even = {1'b0, sum_even_r} + {1'b0, add_even};
    raw_odd  = {1'b0, sum_odd_r}  + {1'b0, add_odd};
    sum_even_nxt = (raw_even >= 5'd10) ? DigitW'(raw_even - 5'd10) : raw_even[DigitW-1:0];
    sum_odd_nxt  = (raw_odd  >= 5'd10) ? DigitW'(raw_odd  - 5'd10) : raw_odd[DigitW-1:0];

    lead_first_nxt  = (count_r == 5'd0) ? d_sat : lead_first_r;
    lead_second_nxt = (count_r == 5'd1) ? d_sat : lead_second_r;
    count_nxt       = (count_r == CountSat) ? count_r : count_r + 5'd1;

    // Pick the sum whose doubled digits sit second from the right
    sum_sel = count_nxt[0] ? sum_odd_nxt : sum_even_nxt;
    luhn_ok = (sum_sel == 4'd0) && (count_nxt <= MaxLen);

    // Classes two and three need length 15 or 16, so both leading digits exist
    priority if (!luhn_ok) begin
      cls = CLASS_INVALID;
    end else if (lead_first_nxt == 4'd4 &&
                 (count_nxt == LenShort || count_nxt == LenLong)) begin
      cls = CLASS_PFX4;
    end else if (lead_first_nxt == 4'd3 &&
                 (lead_second_nxt == 4'd4 || lead_second_nxt == 4'd7) &&
                 count_nxt == LenMid) begin
      cls = CLASS_PFX3X;
    end else if (lead_first_nxt == 4'd5 && lead_second_nxt >= 4'd1 &&
                 lead_second_nxt <= 4'd5 && count_nxt == LenLong) begin
      cls = CLASS_PFX5X;
    end else begin
      cls = CLASS_OTHER;
    end

    out_item_nxt.valid_res   = luhn_ok;
    out_item_nxt.card_class  = cls;
    out_item_nxt.digit_total = count_nxt;

    // Load the result on a last digit, drop it once taken
    if (in_fire && in_data.last_digit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_even_r    <= '0;
      sum_odd_r     <= '0;
      count_r       <= '0;
      lead_first_r  <= '0;
      lead_second_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        if (in_data.last_digit) begin
          // Clear for the next number
          sum_even_r    <= '0;
          sum_odd_r     <= '0;
          count_r       <= '0;
          lead_first_r  <= '0;
          lead_second_r <= '0;
        end else begin
          sum_even_r    <= sum_even_nxt;
          sum_odd_r     <= sum_odd_nxt;
          count_r       <= count_nxt;
          lead_first_r  <= lead_first_nxt;
          lead_second_r <= lead_second_nxt;
        end
      end
    end
  end

  // Result payload: hold while stalled, load on a last digit
  always_ff @(posedge clk) begin
    if (in_fire && in_data.last_digit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`ifndef SYNTHESIS
  a_class_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_item_r.card_class == CLASS_INVALID) == !out_item_r.valid_res))
    else $error("card class disagrees with Luhn validity");

  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.digit_total != 5'd0))
    else $error("result reports zero digits");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last_digit) |=> (count_r == 5'd0 && sum_even_r == 4'd0 &&
                                         sum_odd_r == 4'd0))
    else $error("state not cleared after last digit");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && in_data.last_digit))
    else $error("result raised without a last digit");

  a_sums_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_even_r <= 4'd9) && (sum_odd_r <= 4'd9))
    else $error("running sum left the decimal range");
`endif

endmodule
